### rtl/icms_pkg.sv
// shared types and constants for the inversion counter
// no dependencies

package icms_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned TotalW = 19;
  localparam int unsigned SeenW  = 11;

  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};
  localparam logic [SeenW-1:0]  SeenMax  = {SeenW{1'b1}};

  // control part of a probe that walks down the cell row
  typedef struct packed {
    logic valid;  // probe present in this stage
    logic cmp;    // probe carries a stored element and counts against older ones
    logic last;   // final item of the sequence
  } probe_ctl_t;

endpackage

### rtl/icms_cell.sv
// one cell of the row: holds the element whose arrival index equals CELL_IDX
// and counts older elements greater than a passing probe; uses icms_pkg

module icms_cell #(
  parameter int unsigned CNT_W    = 10,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  icms_pkg::probe_ctl_t                ctl_i,
  input  logic signed [icms_pkg::ValueW-1:0]  value_i,
  input  logic        [CNT_W-1:0]             idx_i,
  input  logic        [CNT_W-1:0]             cnt_i,
  output icms_pkg::probe_ctl_t                ctl_o,
  output logic signed [icms_pkg::ValueW-1:0]  value_o,
  output logic        [CNT_W-1:0]             idx_o,
  output logic        [CNT_W-1:0]             cnt_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(CELL_IDX);

  logic signed [icms_pkg::ValueW-1:0] held_q;
  icms_pkg::probe_ctl_t               ctl_q;
  logic signed [icms_pkg::ValueW-1:0] value_q;
  logic        [CNT_W-1:0]            idx_q;
  logic        [CNT_W-1:0]            cnt_q;
  logic        [CNT_W-1:0]            cnt_d;
  logic                               hit;

  // only cells holding older elements take part in the count
  assign hit   = ctl_i.valid && ctl_i.cmp && (MyIdx < idx_i) && (held_q > value_i);
  assign cnt_d = hit ? cnt_i + CNT_W'(1) : cnt_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_i;
    idx_q   <= idx_i;
    cnt_q   <= cnt_d;
    if (ctl_i.valid && ctl_i.cmp && (idx_i == MyIdx)) begin
      held_q <= value_i;
    end
  end

  assign ctl_o   = ctl_q;
  assign value_o = value_q;
  assign idx_o   = idx_q;
  assign cnt_o   = cnt_q;

endmodule

### rtl/inversion_count_merge_sort.sv
// top level of the inversion counter: input staging, row of icms_cell, result register
// depends on icms_pkg and icms_cell
//
// usage:
//   items (value_i, last_i) enter on the in channel; an item is taken when
//   in_valid_i is high and in_stall_o is low. every stored item becomes a probe
//   that walks the cell row one cell per cycle, counting older elements that
//   are strictly greater, and drops its value into the cell of its own index.
//   items past MAX_ITEMS are dropped and set the overflow flag.
//   an item with last_i set closes the sequence: the input stalls until the
//   result is taken. the result (inversion_total_o, items_seen_o, overflow_o)
//   appears once the closing probe has passed the entry register, every cell
//   of the row and the result register. loading takes one item per cycle
//   while in_stall_o is low. the result holds while out_stall_i is high;
//   the next sequence starts in the cycle after it is taken.
//   reset clears the fill count, the drop flag and all valid state;
//   cell contents need no clearing since a probe only looks at lower indexes.

module inversion_count_merge_sort #(
  parameter int unsigned MAX_ITEMS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [icms_pkg::ValueW-1:0]  value_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [icms_pkg::TotalW-1:0]  inversion_total_o,
  output logic        [icms_pkg::SeenW-1:0]   items_seen_o,
  output logic                                overflow_o
);

  localparam int unsigned CntW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned FillW   = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SumW    = ((CntW > icms_pkg::TotalW) ? CntW : icms_pkg::TotalW) + 1;
  localparam int unsigned SeenCmpW = (FillW > icms_pkg::SeenW) ? FillW : icms_pkg::SeenW;
  localparam logic [FillW-1:0] FillMax = FillW'(MAX_ITEMS);

  logic in_acc;
  logic stored;
  logic out_acc;

  logic [FillW-1:0] fill_q, fill_d;
  logic             dropped_q;
  logic             busy_q;

  // probe stages: index 0 is the entry register, MAX_ITEMS is the row exit
  icms_pkg::probe_ctl_t               ctl   [0:MAX_ITEMS];
  logic signed [icms_pkg::ValueW-1:0] value [0:MAX_ITEMS];
  logic        [CntW-1:0]             idx   [0:MAX_ITEMS];
  logic        [CntW-1:0]             cnt   [0:MAX_ITEMS];

  icms_pkg::probe_ctl_t               entry_ctl_q;
  logic signed [icms_pkg::ValueW-1:0] entry_value_q;
  logic        [CntW-1:0]             entry_idx_q;

  logic [icms_pkg::TotalW-1:0] acc_q;
  logic [SumW-1:0]             sum;
  logic [icms_pkg::TotalW-1:0] sum_sat;

  logic [FillW-1:0]            seen_d;
  logic [SeenCmpW-1:0]         seen_cmp;
  logic [icms_pkg::SeenW-1:0]  seen_sat;
  logic [icms_pkg::SeenW-1:0]  seen_q;
  logic                        ovf_q;

  logic                        out_valid_q;
  logic [icms_pkg::TotalW-1:0] total_q;
  logic                        exit_last;

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;
  assign stored     = (fill_q != FillMax);
  assign out_acc    = out_valid_q && !out_stall_i;

  assign fill_d = stored ? fill_q + FillW'(1) : fill_q;
  assign seen_d = fill_d;

  assign seen_cmp = SeenCmpW'(seen_d);
  assign seen_sat = (seen_cmp > SeenCmpW'(icms_pkg::SeenMax)) ? icms_pkg::SeenMax
                                                              : seen_cmp[icms_pkg::SeenW-1:0];

  // fill count, drop flag, busy flag and entry probe control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      dropped_q   <= 1'b0;
      busy_q      <= 1'b0;
      entry_ctl_q <= '0;
    end else begin
      entry_ctl_q.valid <= in_acc && (stored || last_i);
      entry_ctl_q.cmp   <= stored;
      entry_ctl_q.last  <= last_i;
      if (in_acc) begin
        if (last_i) begin
          fill_q    <= '0;
          dropped_q <= 1'b0;
          busy_q    <= 1'b1;
        end else begin
          fill_q    <= fill_d;
          dropped_q <= dropped_q | !stored;
        end
      end else if (out_acc) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_value_q <= value_i;
    entry_idx_q   <= fill_q[CntW-1:0];
    if (in_acc && last_i) begin
      seen_q <= seen_sat;
      ovf_q  <= dropped_q | !stored;
    end
  end

  assign ctl[0]   = entry_ctl_q;
  assign value[0] = entry_value_q;
  assign idx[0]   = entry_idx_q;
  assign cnt[0]   = '0;

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    icms_cell #(
      .CNT_W   (CntW),
      .CELL_IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[g]),
      .value_i(value[g]),
      .idx_i  (idx[g]),
      .cnt_i  (cnt[g]),
      .ctl_o  (ctl[g+1]),
      .value_o(value[g+1]),
      .idx_o  (idx[g+1]),
      .cnt_o  (cnt[g+1])
    );
  end

  // saturating accumulation of per-probe counts at the row exit
  assign sum       = SumW'(acc_q) + SumW'(cnt[MAX_ITEMS]);
  assign sum_sat   = (sum > SumW'(icms_pkg::TotalMax)) ? icms_pkg::TotalMax
                                                       : sum[icms_pkg::TotalW-1:0];
  assign exit_last = ctl[MAX_ITEMS].valid && ctl[MAX_ITEMS].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl[MAX_ITEMS].valid) begin
        acc_q <= ctl[MAX_ITEMS].last ? '0 : sum_sat;
      end
      if (exit_last) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exit_last) begin
      total_q <= sum_sat;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign inversion_total_o = total_q;
  assign items_seen_o      = seen_q;
  assign overflow_o        = ovf_q;

  // a pending result always keeps the input closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> busy_q)
    else $error("result pending while input open");

  // the closing probe only leaves the row while the sequence is closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_last |-> (busy_q && !out_valid_q))
    else $error("closing probe left the row unexpectedly");

  // taking the last item starts a fresh sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_i) |=> (fill_q == '0 && !dropped_q && busy_q))
    else $error("sequence state not cleared after last item");

  // the fill count never passes capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax)
    else $error("fill count beyond capacity");

endmodule
